// ===== src/mlp_pkg.sv =====
// Package for the manifest line parser: word and result types, the parse
// phase enum, character codes and the magic byte table. No dependencies.
package mlp_pkg;

  localparam int MAGIC_LEN = 5;
  localparam int HASH_LEN  = 8;
  localparam int POS_W     = 3;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_F   = 8'h66;

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_FIRST   = 3'd1,
    PH_DIGITS  = 3'd2,
    PH_HASH    = 3'd3,
    PH_NEWLINE = 3'd4,
    PH_END     = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        valid_res;
    logic [31:0] size_value;
    logic [31:0] hash_value;
  } res_t;

  // Expected byte of the "GWW1 " magic at a given position.
  function automatic logic [7:0] magic_byte(input logic [POS_W-1:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'h47;  // 'G'
      3'd1:    b = 8'h57;  // 'W'
      3'd2:    b = 8'h57;  // 'W'
      3'd3:    b = 8'h31;  // '1'
      3'd4:    b = CH_SPACE;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/mlp_in_stage.sv =====
// Input register of the manifest line parser: captures one word per cycle
// unless the stage is held. Depends on mlp_pkg.
module mlp_in_stage
  import mlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte_in,
  input  logic       in_last_byte,
  input  logic       hold,
  output logic       word_valid,
  output in_word_t   word
);

  logic     word_valid_r;
  in_word_t word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_valid_r <= 1'b0;
    end else if (!hold) begin
      word_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      word_r.byte_in   <= in_byte_in;
      word_r.last_byte <= in_last_byte;
    end
  end

  assign word_valid = word_valid_r;
  assign word       = word_r;

endmodule

// ===== src/mlp_parse_core.sv =====
// Parse state of the manifest line parser and its next-state logic; forms
// the result for the final word of a line. Depends on mlp_pkg.
module mlp_parse_core
  import mlp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     consume,
  input  in_word_t word,
  output logic     res_fire,
  output res_t     res
);

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      size_r, size_nxt;
  logic [31:0]      hash_r, hash_nxt;
  logic             failed_r, failed_nxt;

  logic        is_dig;
  logic        is_hex_lc;
  logic [3:0]  hex_val;
  logic [35:0] size_mac;
  logic        size_ovf;

  assign is_dig    = (word.byte_in >= CH_ZERO) && (word.byte_in <= CH_NINE);
  assign is_hex_lc = (word.byte_in >= CH_LOW_A) && (word.byte_in <= CH_LOW_F);
  assign hex_val   = is_dig ? word.byte_in[3:0] : 4'(word.byte_in[3:0] + 4'd9);

  // size * 10 + digit in 36 bits; any carry into the top four bits overflows.
  assign size_mac = {1'b0, size_r, 3'b000} + {3'b000, size_r, 1'b0}
                  + {32'd0, word.byte_in[3:0]};
  assign size_ovf = |size_mac[35:32];

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    size_nxt   = size_r;
    hash_nxt   = hash_r;
    failed_nxt = failed_r;

    if (!failed_r) begin
      unique case (phase_r)
        PH_MAGIC: begin
          if (pos_r >= POS_W'(MAGIC_LEN) || word.byte_in != magic_byte(pos_r)) begin
            failed_nxt = 1'b1;
          end else if (pos_r == POS_W'(MAGIC_LEN - 1)) begin
            phase_nxt = PH_FIRST;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
        PH_FIRST: begin
          if (!is_dig || size_ovf) begin
            failed_nxt = 1'b1;
          end else begin
            size_nxt  = size_mac[31:0];
            phase_nxt = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          if (is_dig) begin
            if (size_ovf) failed_nxt = 1'b1;
            else          size_nxt   = size_mac[31:0];
          end else if (word.byte_in == CH_SPACE) begin
            phase_nxt = PH_HASH;
            pos_nxt   = '0;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_HASH: begin
          if (is_dig || is_hex_lc) begin
            hash_nxt = {hash_r[27:0], hex_val};
            if (pos_r == POS_W'(HASH_LEN - 1)) begin
              phase_nxt = PH_NEWLINE;
              pos_nxt   = '0;
            end else begin
              pos_nxt = pos_r + POS_W'(1);
            end
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_NEWLINE: begin
          if (word.byte_in == CH_NEWLINE) phase_nxt  = PH_END;
          else                            failed_nxt = 1'b1;
        end
        default: begin
          failed_nxt = 1'b1;
        end
      endcase
    end

    res.valid_res  = !failed_nxt && (phase_nxt == PH_END);
    res.size_value = res.valid_res ? size_nxt : 32'd0;
    res.hash_value = res.valid_res ? hash_nxt : 32'd0;

    // The final word of a line reports and then starts the next line afresh.
    if (word.last_byte) begin
      phase_nxt  = PH_MAGIC;
      pos_nxt    = '0;
      size_nxt   = 32'd0;
      hash_nxt   = 32'd0;
      failed_nxt = 1'b0;
    end
  end

  assign res_fire = consume && word.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC;
      pos_r    <= '0;
      size_r   <= 32'd0;
      hash_r   <= 32'd0;
      failed_r <= 1'b0;
    end else if (consume) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      size_r   <= size_nxt;
      hash_r   <= hash_nxt;
      failed_r <= failed_nxt;
    end
  end

  a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |=> (phase_r == PH_MAGIC) && (pos_r == '0) && !failed_r
                 && (size_r == 32'd0) && (hash_r == 32'd0))
    else $error("parse state not cleared after the final word of a line");

  a_magic_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_MAGIC) |-> (pos_r < POS_W'(MAGIC_LEN)))
    else $error("magic position out of range");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (failed_r && !res_fire) |=> failed_r)
    else $error("failure flag dropped within a line");

endmodule

// ===== src/mlp_out_stage.sv =====
// Result register of the manifest line parser: holds one result word until
// the receiver takes it. Depends on mlp_pkg.
module mlp_out_stage
  import mlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_fire,
  input  res_t        res,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        out_valid_res,
  output logic [31:0] out_size_value,
  output logic [31:0] out_hash_value
);

  logic out_valid_r;
  res_t res_r;
  logic load;

  assign load = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_fire) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_valid_res  = res_r.valid_res;
  assign out_size_value = res_r.size_value;
  assign out_hash_value = res_r.hash_value;

endmodule

// ===== src/manifest_line_parser_unit.sv =====
// Top level of the manifest line parser: input register, parse core and
// result register. Depends on mlp_pkg, mlp_in_stage, mlp_parse_core, mlp_out_stage.

// The block takes a manifest line one byte per word, with in_last_byte set on
// the final byte, and checks it against the form "GWW1 ", one or more decimal
// digits (a 32-bit size), one space, exactly eight lowercase hex digits (a
// 32-bit hash) and a newline as the very last byte. Exactly one result word
// leaves for each line, on the word that carried in_last_byte: out_valid_res
// says whether the line matched, and out_size_value and out_hash_value carry
// the parsed values, or zero when the line did not match. A size digit that
// would carry the size past 2^32-1 makes the line invalid, as do uppercase hex
// digits and any byte after the newline. Once a line has failed, its remaining
// bytes are taken and ignored. One word is accepted in every cycle while
// in_stall is low. The final byte of a line passes through the input register
// and then the result register before out_valid rises. The parse state is
// updated once per accepted word; for a size digit this is a multiply-by-ten
// add with overflow check. While a result waits in the result register, bytes
// that do not end a line keep flowing; only a second line-ending word stalls
// the input until the receiver takes the waiting result.
module manifest_line_parser_unit
  import mlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic [31:0] out_size_value,
  output logic [31:0] out_hash_value
);

  logic     word_valid;
  in_word_t word;
  logic     blocked;
  logic     consume;
  logic     res_fire;
  res_t     res;

  // A line-ending word can only move on when the result register is free.
  assign blocked  = word_valid && word.last_byte && out_valid && out_stall;
  assign consume  = word_valid && !blocked;
  assign in_stall = blocked;

  mlp_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_byte_in   (in_byte_in),
    .in_last_byte (in_last_byte),
    .hold         (blocked),
    .word_valid   (word_valid),
    .word         (word)
  );

  mlp_parse_core u_parse_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .consume  (consume),
    .word     (word),
    .res_fire (res_fire),
    .res      (res)
  );

  mlp_out_stage u_out_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_fire       (res_fire),
    .res            (res),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_valid_res  (out_valid_res),
    .out_size_value (out_size_value),
    .out_hash_value (out_hash_value)
  );

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> (out_size_value == 32'd0)
                                      && (out_hash_value == 32'd0))
    else $error("invalid line reported with non-zero values");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (word_valid && word.last_byte && out_valid))
    else $error("input stalled without a waiting line-ending word");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for manifest_line_parser_unit: directed and random
// manifest lines with random gaps and stalls on both sides. Depends on mlp_pkg.
module testbench;
  import mlp_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  // The directed lines add roughly another 235 bytes on top of these.
  localparam int RANDOM_BYTES = 1715;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [39:0] MAGIC_TEXT = "GWW1 ";

  // One byte of stimulus; hold makes the sender wait until every line sent so
  // far has been answered before it offers this word.
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       hold;
  } line_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_in = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_valid_res;
  logic [31:0] out_size_value;
  logic [31:0] out_hash_value;

  manifest_line_parser_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_in    (in_byte_in),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_size_value(out_size_value),
    .out_hash_value(out_hash_value)
  );

  always #5 clk = ~clk;

  // Stimulus and expectations.
  line_byte_t pending_bytes[$];
  logic [7:0] line_buf[$];
  res_t       expected_lines[$];

  int fail_count = 0;
  int bytes_sent = 0;
  int lines_checked = 0;
  int lines_matched = 0;
  int cycle_count = 0;

  // The parser as the testbench sees it: one line in progress at a time.
  phase_t      ln_phase = PH_MAGIC;
  logic [2:0]  ln_pos = '0;
  logic [31:0] ln_size = '0;
  logic [31:0] ln_hash = '0;
  logic        ln_failed = 1'b0;

  // Advances the line state by one byte and, on the final byte of a line,
  // queues the result that the block must return for it.
  task automatic track_line_byte(input logic [7:0] c, input logic last);
    logic        is_dec;
    logic [63:0] grown;
    logic [3:0]  nib;
    res_t        res;
    is_dec = (c >= CH_ZERO) && (c <= CH_NINE);
    if (!ln_failed) begin
      case (ln_phase) inside
        PH_MAGIC: begin
          if (ln_pos >= MAGIC_LEN || c != MAGIC_TEXT[39 - 8 * int'(ln_pos) -: 8]) begin
            ln_failed = 1'b1;
          end else if (ln_pos == MAGIC_LEN - 1) begin
            ln_phase = PH_FIRST;
            ln_pos = '0;
          end else begin
            ln_pos = ln_pos + 3'd1;
          end
        end
        PH_FIRST, PH_DIGITS: begin
          if (is_dec) begin
            // The size must stay within 32 bits after each multiply-by-ten.
            grown = {32'b0, ln_size} * 64'd10 + {56'b0, c - CH_ZERO};
            if (grown > 64'hFFFF_FFFF) begin
              ln_failed = 1'b1;
            end else begin
              ln_size = grown[31:0];
              ln_phase = PH_DIGITS;
            end
          end else if (ln_phase == PH_DIGITS && c == CH_SPACE) begin
            ln_phase = PH_HASH;
            ln_pos = '0;
          end else begin
            ln_failed = 1'b1;
          end
        end
        PH_HASH: begin
          // Only lowercase hex digits count; uppercase ones break the line.
          if (is_dec || (c >= CH_LOW_A && c <= CH_LOW_F)) begin
            nib = is_dec ? 4'(c - CH_ZERO) : 4'(c - CH_LOW_A + 8'd10);
            ln_hash = {ln_hash[27:0], nib};
            if (ln_pos == HASH_LEN - 1) begin
              ln_phase = PH_NEWLINE;
              ln_pos = '0;
            end else begin
              ln_pos = ln_pos + 3'd1;
            end
          end else begin
            ln_failed = 1'b1;
          end
        end
        PH_NEWLINE: begin
          if (c == CH_NEWLINE) ln_phase = PH_END;
          else ln_failed = 1'b1;
        end
        default: begin
          // Anything after the newline, or a phase that cannot occur.
          ln_failed = 1'b1;
        end
      endcase
    end
    if (last) begin
      res.valid_res  = !ln_failed && ln_phase == PH_END;
      res.size_value = res.valid_res ? ln_size : 32'd0;
      res.hash_value = res.valid_res ? ln_hash : 32'd0;
      expected_lines.push_back(res);
      ln_phase = PH_MAGIC;
      ln_pos = '0;
      ln_size = '0;
      ln_hash = '0;
      ln_failed = 1'b0;
    end
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // Fills the line buffer with a well-formed line, size with leading zeros.
  task automatic build_good_line(input logic [31:0] size, input logic [31:0] hash,
                                 input int zeros);
    line_buf.delete();
    append_text("GWW1 ");
    for (int i = 0; i < zeros; i++) line_buf.push_back("0");
    append_text($sformatf("%0d %08x\n", size, hash));
  endtask

  // Moves the line buffer to the send queue, the last word flagged.
  task automatic send_line(input bit hold);
    line_byte_t w;
    for (int i = 0; i < line_buf.size(); i++) begin
      w.b    = line_buf[i];
      w.last = (i == line_buf.size() - 1);
      w.hold = hold && (i == 0);
      pending_bytes.push_back(w);
    end
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    append_text(s);
    send_line(1'b0);
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 99);
      1:       return $urandom;
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 20);
      default: return $urandom_range(0, 99999);
    endcase
  endfunction

  // Breaks a well-formed line in the buffer in one of several ways.
  task automatic spoil_line();
    int n;
    n = line_buf.size();
    case ($urandom_range(0, 7))
      0: begin
        // Line cut short before its newline.
        repeat ($urandom_range(1, n - 1)) line_buf.delete(line_buf.size() - 1);
      end
      1: line_buf[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
      2: line_buf[n - 9 + $urandom_range(0, 7)] = 8'(8'h41 + $urandom_range(0, 5));
      3: repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(0, 255)));
      4: begin
        // Size one step or more beyond 32 bits.
        line_buf.delete();
        append_text($sformatf("GWW1 %0d %08x\n",
                              64'd4294967296 + $urandom_range(0, 32'h3FFF_FFFF),
                              $urandom));
      end
      5: begin
        if ($urandom_range(0, 1) == 1) line_buf.delete(n - 2);
        else line_buf.insert(n - 1, "7");
      end
      6: line_buf[n - 1] = 8'($urandom_range(0, 255));
      default: line_buf.insert(5, " ");
    endcase
  endtask

  // Sender: offers one word at a time, with a random gap after each accepted
  // word. Now and then the gaps switch off for a stretch of back-to-back words.
  int send_gap = 0;
  bit send_calm = 1'b0;

  always @(posedge clk) begin
    line_byte_t nxt;
    logic       next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_byte_in <= 8'h00;
      in_last_byte <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        track_line_byte(in_byte_in, in_last_byte);
        bytes_sent++;
        next_valid = 1'b0;
        if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 17);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_bytes.size() > 0 &&
                     !(pending_bytes[0].hold && expected_lines.size() > 0)) begin
          nxt = pending_bytes.pop_front();
          in_byte_in <= nxt.b;
          in_last_byte <= nxt.last;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Receiver: after each result it stalls for a random number of cycles, and
  // every result is checked against the oldest expectation.
  int recv_wait = 0;
  bit recv_calm = 1'b0;

  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_lines.size() == 0) begin
          $error("result word with no line outstanding");
          fail_count++;
        end else begin
          want = expected_lines.pop_front();
          lines_checked++;
          if (want.valid_res) lines_matched++;
          if (out_valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, out_valid_res);
            fail_count++;
          end
          if (out_size_value !== want.size_value) begin
            $error("size_value: expected %0d, got %0d", want.size_value, out_size_value);
            fail_count++;
          end
          if (out_hash_value !== want.hash_value) begin
            $error("hash_value: expected %08x, got %08x", want.hash_value, out_hash_value);
            fail_count++;
          end
        end
        if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 17);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait > 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timed out with %0d lines outstanding", expected_lines.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int  random_bytes;
    int  pick;
    bit  first_random;
    // Directed lines: extremes of size and hash, then one of each way to fail.
    build_good_line(32'd0, 32'h0000_0000, 0);
    send_line(1'b0);
    build_good_line(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_line(1'b0);
    build_good_line(32'd123, 32'h0a1b_2c3d, 3);
    send_line(1'b0);
    send_text("GWW1 4294967296 ffffffff\n");
    send_text("GWW1 42949672950 01234567\n");
    send_text("GWW1 12 DEADBEEF\n");
    send_text("GWW1 1 0123abcd\nX");
    send_text("GWW1 12");
    send_text("GWX1 5 89abcdef\n");
    send_text("GWW1  89abcdef\n");
    send_text("GWW1 5 89abcde\n");
    send_text("GWW1 5 89abcdef0\n");
    send_text("GWW1 5 89abcdef ");
    line_buf.delete();
    line_buf.push_back(8'hFF);
    send_line(1'b0);
    line_buf.delete();
    line_buf.push_back(8'h00);
    send_line(1'b0);

    // Random lines: mostly well formed, some spoilt, some pure noise.
    random_bytes = 0;
    first_random = 1'b1;
    while (random_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        build_good_line(pick_size(), $urandom,
                        ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
        if (pick >= 55) spoil_line();
      end else begin
        line_buf.delete();
        repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
      end
      random_bytes += line_buf.size();
      send_line(first_random || $urandom_range(0, 24) == 0);
      first_random = 1'b0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() > 0 || in_valid) @(posedge clk);
    while (expected_lines.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; %0d lines checked, of which %0d were well formed.",
             bytes_sent, lines_checked, lines_matched);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/mlp_pkg.sv
src/mlp_in_stage.sv
src/mlp_parse_core.sv
src/mlp_out_stage.sv
src/manifest_line_parser_unit.sv
sim/testbench.sv
